@@ design/crcled_pkg.sv @@
// shared types, command codes and tables for the crc-checked led command receiver
`timescale 1ns / 1ps

package crcled_pkg;

  localparam int STORE_DEPTH  = 24;
  localparam int PAYLOAD_BITS = STORE_DEPTH * 8;
  localparam int COUNT_W      = 5;
  localparam int STEP_W       = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [3:0] CMD_SET_ALL_LATCH = 4'h1;
  localparam logic [3:0] CMD_SET_ONE_LATCH = 4'h2;
  localparam logic [3:0] CMD_PULSE         = 4'h3;
  localparam logic [3:0] CMD_LATCH         = 4'h4;
  localparam logic [3:0] CMD_SET_EVERY     = 4'h6;
  localparam logic [3:0] CMD_SET_ALL       = 4'h7;
  localparam logic [3:0] CMD_SET_ONE       = 4'h8;

  typedef enum logic [1:0] {
    ACT_SET_ONE = 2'd0,
    ACT_SET_ALL = 2'd1,
    ACT_LATCH   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  // one good, addressed frame handed from the front to the back
  typedef struct packed {
    logic [3:0]              cmd;
    logic [PAYLOAD_BITS-1:0] payload;
  } job_t;

  typedef struct packed {
    action_t     led_action;
    logic [3:0]  channel;
    logic [11:0] level;
    logic        last_of_frame;
  } result_t;

  function automatic logic [COUNT_W-1:0] payload_len(input logic [3:0] cmd);
    logic [COUNT_W-1:0] len;
    unique case (cmd)
      CMD_SET_ALL_LATCH: len = COUNT_W'(1);
      CMD_SET_ONE_LATCH: len = COUNT_W'(2);
      CMD_PULSE:         len = COUNT_W'(3);
      CMD_SET_EVERY:     len = COUNT_W'(STORE_DEPTH);
      CMD_SET_ALL:       len = COUNT_W'(1);
      CMD_SET_ONE:       len = COUNT_W'(2);
      default:           len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ design/crcled_front.sv @@
// frame receiver: header, payload store, crc-8 check and job hand-off
`timescale 1ns / 1ps

module crcled_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  output logic                full,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  output logic                cfg_ready,
  input  logic                q_full,
  output logic                job_push,
  output crcled_pkg::job_t    job
);
  import crcled_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         board_address;
  logic [7:0]         header_byte;
  logic [7:0]         running_crc;
  logic [COUNT_W-1:0] payload_count;
  logic [7:0]         store [STORE_DEPTH];

  logic               accept;
  logic [COUNT_W-1:0] len_cur, len_hdr, count_inc;
  logic               addr_ok, has_results, crc_ok;

  // reflected crc-8, polynomial 0x31, one bit per step
  function automatic logic [7:0] crc_byte(input logic [7:0] data, input logic [7:0] crc);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = ((c ^ 8'h18) >> 1) | 8'h80;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  assign accept    = push && !full;
  assign len_cur   = payload_len(header_byte[3:0]);
  assign len_hdr   = payload_len(rx_byte[3:0]);
  assign count_inc = payload_count + COUNT_W'(1);
  assign cfg_ready = 1'b1;

  assign addr_ok = (header_byte[7:4] == 4'h0) || ({header_byte[7:4], 4'h0} == board_address);
  assign crc_ok  = (rx_byte == running_crc);

  always_comb begin
    case (header_byte[3:0]) inside
      CMD_SET_ALL_LATCH, CMD_SET_ONE_LATCH, CMD_PULSE, CMD_LATCH,
      CMD_SET_EVERY, CMD_SET_ALL, CMD_SET_ONE: has_results = 1'b1;
      default:                                 has_results = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD: begin
          if (count_inc >= len_cur) phase_next = PH_CHECK;
        end
        PH_CHECK: phase_next = PH_HEADER;
        default: begin
          phase_next = (len_hdr == '0) ? PH_CHECK : PH_PAYLOAD;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    full     = 1'b0;
    job_push = 1'b0;
    unique case (phase)
      PH_CHECK: begin
        full     = q_full;
        job_push = push && !q_full && crc_ok && addr_ok && has_results;
      end
      default: begin
        full     = 1'b0;
        job_push = 1'b0;
      end
    endcase
  end

  always_comb begin
    job.cmd = header_byte[3:0];
    for (int k = 0; k < STORE_DEPTH; k++) begin
      job.payload[k*8 +: 8] = store[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      board_address <= 8'h10;
      header_byte   <= '0;
      running_crc   <= '0;
      payload_count <= '0;
    end else begin
      phase <= phase_next;
      if (cfg_valid && cfg_ready) begin
        board_address <= cfg_data;
      end
      if (accept) begin
        unique case (phase)
          PH_PAYLOAD: begin
            running_crc   <= crc_byte(rx_byte, running_crc);
            payload_count <= count_inc;
          end
          PH_CHECK: begin
          end
          default: begin
            header_byte   <= rx_byte;
            running_crc   <= crc_byte(rx_byte, 8'h00);
            payload_count <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_PAYLOAD) && (payload_count < COUNT_W'(STORE_DEPTH))) begin
      store[payload_count] <= rx_byte;
    end
  end

endmodule

@@ design/crcled_queue.sv @@
// short job queue between the frame receiver and the command sequencer
`timescale 1ns / 1ps

module crcled_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crcled_pkg::job_t  job_in,
  output logic              full,
  input  logic              pop,
  output crcled_pkg::job_t  job_out,
  output logic              valid
);
  import crcled_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign job_out = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= job_in;
  end

endmodule

@@ design/crcled_back.sv @@
// command sequencer: turns one job into led results through an output register
`timescale 1ns / 1ps

module crcled_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  crcled_pkg::job_t     job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_pop,
  output crcled_pkg::result_t  out_res
);
  import crcled_pkg::*;

  logic [STEP_W-1:0] step;
  result_t           res;
  logic              load;
  logic [7:0]        p0, p1, ga, gb, gc;
  logic [23:0]       group;

  assign p0    = job.payload[7:0];
  assign p1    = job.payload[15:8];
  // three payload bytes feed each pair of channels
  assign group = job.payload[step[STEP_W-1:1]*24 +: 24];
  assign ga    = group[7:0];
  assign gb    = group[15:8];
  assign gc    = group[23:16];

  assign load    = job_valid && (!out_valid || out_pop);
  assign job_pop = load && res.last_of_frame;

  always_comb begin
    res.led_action    = ACT_LATCH;
    res.channel       = '0;
    res.level         = '0;
    res.last_of_frame = 1'b1;
    unique case (job.cmd) inside
      CMD_SET_ALL_LATCH, CMD_SET_ALL: begin
        if (step[0] == 1'b0) begin
          res.led_action    = ACT_SET_ALL;
          res.level         = {p0, 4'h0};
          res.last_of_frame = (job.cmd == CMD_SET_ALL);
        end
      end
      CMD_SET_ONE_LATCH, CMD_SET_ONE, CMD_PULSE: begin
        if (step[0] == 1'b0) begin
          res.led_action    = ACT_SET_ONE;
          res.channel       = p0[7:4];
          res.level         = {p0[3:0], p1};
          res.last_of_frame = (job.cmd != CMD_SET_ONE_LATCH);
        end
      end
      CMD_SET_EVERY: begin
        res.led_action    = ACT_SET_ONE;
        res.channel       = step;
        res.level         = (step[0] == 1'b0) ? {ga, gb[7:4]} : {gb[3:0], gc};
        res.last_of_frame = (step == '1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= res.last_of_frame ? '0 : step + STEP_W'(1);
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= res;
  end

endmodule

@@ design/crc_checked_led_command_receiver_core.sv @@
// top level of the crc-checked led command receiver
//
//   channel   signals                              beat taken when
//   input     push, full, rx_byte                  push && !full
//   results   empty, pop, led_action, channel,     pop && !empty
//             level, last_of_frame
//   config    cfg_valid, cfg_ready, cfg_data       cfg_valid && cfg_ready
//
// the receiver takes one byte per cycle while full is low; full rises only on
// a check byte while both job slots are taken. the sequencer gives one result
// per cycle while pop keeps up. a set-every job gives 16 results, others 1 or 2.
// reset clears the frame state and empties the job queue and output register.
// results wait in the output register, a stalled pop never blocks the receiver
// until the job queue fills.
`timescale 1ns / 1ps

module crc_checked_led_command_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  led_action,
  output logic [3:0]  channel,
  output logic [11:0] level,
  output logic        last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import crcled_pkg::*;

  job_t    front_job, head_job;
  logic    job_push, q_full, job_pop, head_valid, out_valid;
  result_t out_res;

  crcled_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (front_job)
  );

  crcled_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (front_job),
    .full    (q_full),
    .pop     (job_pop),
    .job_out (head_job),
    .valid   (head_valid)
  );

  crcled_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_pop   (pop),
    .out_res   (out_res)
  );

  assign empty         = !out_valid;
  assign led_action    = out_res.led_action;
  assign channel       = out_res.channel;
  assign level         = out_res.level;
  assign last_of_frame = out_res.last_of_frame;

  // a job is never offered to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(job_push && q_full))
    else $error("job pushed into a full queue");

  a_channel_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (led_action != ACT_SET_ONE)) |-> (channel == 4'h0))
    else $error("channel not zero on set-all or latch");

  a_latch_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (led_action == ACT_LATCH)) |-> ((level == 12'h000) && last_of_frame))
    else $error("latch beat with level or not last of frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result visible right after reset");

endmodule
